FILE: rtl/csc_pkg.sv
`default_nettype none

package csc_pkg;

    localparam int TRANSACTIONS = 16;
    localparam int ITEMS        = 256;

    localparam int TXN_W   = 4;
    localparam int ITEM_W  = 8;
    localparam int TXN_AW  = $clog2(TRANSACTIONS);
    localparam int ITEM_AW = $clog2(ITEMS);

    typedef logic [TRANSACTIONS-1:0] mask_t;

    typedef struct packed {
        mask_t wr;
        mask_t rd;
    } entry_t;

endpackage

`default_nettype wire

FILE: rtl/conflict_serializability_check.sv
// Conflict serializability checker (precedence graph test).
// Command channel: a beat is taken at a rising edge with start high and busy
// low. action = 0 is a schedule operation (transaction, is_write, data_item);
// action = 1 evaluates the schedule collected so far and clears it.
// Result channel: done is high for exactly one cycle with serializable valid;
// the receiver cannot hold it off. Only evaluate beats give a result.
// Sequence: an operation does a synchronous read of the item's reader/writer
// masks at the accepting edge, then an update state updates the graph and
// writes them back. An evaluate beat closes the graph one pivot row per
// cycle (all rows in parallel) through every pivot, then a report state
// registers done and serializable; it then sweeps the mask memory, one entry
// a cycle, through every entry before busy falls again.
// Reset: the graph rows clear at once; the mask memory is swept through every
// entry (busy high) before the first beat is taken.
// Operations naming a transaction or item out of range change nothing.
`default_nettype none

module conflict_serializability_check (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      start,
    output logic                           busy,
    input  wire logic                      action,
    input  wire logic [csc_pkg::TXN_W-1:0] transaction,
    input  wire logic                      is_write,
    input  wire logic [csc_pkg::ITEM_W-1:0] data_item,
    output logic                           done,
    output logic                           serializable
);

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_UPD    = 5'b00010,
        ST_CLOSE  = 5'b00100,
        ST_REPORT = 5'b01000,
        ST_CLEAR  = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    csc_pkg::entry_t mem [csc_pkg::ITEMS];
    csc_pkg::entry_t rd_data_reg;

    csc_pkg::mask_t rows_reg [csc_pkg::TRANSACTIONS];
    csc_pkg::mask_t rows_next [csc_pkg::TRANSACTIONS];

    logic [csc_pkg::TXN_AW-1:0]  op_txn_reg;
    logic                        op_wr_reg;
    logic [csc_pkg::ITEM_AW-1:0] op_item_reg;
    logic                        op_ok_reg;
    logic [csc_pkg::TXN_AW-1:0]  k_reg, k_next;
    logic [csc_pkg::ITEM_AW-1:0] clr_reg, clr_next;
    logic                        done_reg, done_next;
    logic                        ser_reg, ser_next;

    logic                        accept;
    logic                        in_range;
    logic [csc_pkg::ITEM_AW-1:0] rd_addr;
    logic                        mem_we;
    logic [csc_pkg::ITEM_AW-1:0] mem_waddr;
    csc_pkg::entry_t             mem_wdata;
    csc_pkg::entry_t             upd_entry;
    csc_pkg::mask_t              self_mask;
    csc_pkg::mask_t              sources;
    logic                        cyclic;

    assign busy         = (state_reg != ST_IDLE);
    assign accept       = start && !busy;
    assign done         = done_reg;
    assign serializable = ser_reg;

    assign in_range = (32'(transaction) < csc_pkg::TRANSACTIONS)
                   && (32'(data_item) < csc_pkg::ITEMS);
    assign rd_addr  = data_item[csc_pkg::ITEM_AW-1:0];

    assign self_mask = csc_pkg::mask_t'(1) << op_txn_reg;
    assign sources   = (rd_data_reg.wr | (op_wr_reg ? rd_data_reg.rd : '0)) & ~self_mask;

    always_comb
    begin
        upd_entry = rd_data_reg;
        if (op_wr_reg)
        begin
            upd_entry.wr = rd_data_reg.wr | self_mask;
        end
        else
        begin
            upd_entry.rd = rd_data_reg.rd | self_mask;
        end
    end

    always_comb
    begin
        cyclic = 1'b0;
        for (int i = 0; i < csc_pkg::TRANSACTIONS; i++)
        begin
            cyclic = cyclic | rows_reg[i][i];
        end
    end

    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = op_item_reg;
        mem_wdata = upd_entry;
        if (state_reg == ST_UPD)
        begin
            mem_we = op_ok_reg;
        end
        else if (state_reg == ST_CLEAR)
        begin
            mem_we    = 1'b1;
            mem_waddr = clr_reg;
            mem_wdata = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_txn_reg  <= transaction[csc_pkg::TXN_AW-1:0];
            op_wr_reg   <= is_write;
            op_item_reg <= data_item[csc_pkg::ITEM_AW-1:0];
            op_ok_reg   <= in_range;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        k_next     = k_reg;
        clr_next   = clr_reg;
        done_next  = 1'b0;
        ser_next   = ser_reg;
        for (int i = 0; i < csc_pkg::TRANSACTIONS; i++)
        begin
            rows_next[i] = rows_reg[i];
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (action)
                    begin
                        k_next     = '0;
                        state_next = ST_CLOSE;
                    end
                    else
                    begin
                        state_next = ST_UPD;
                    end
                end
            end
            ST_UPD:
            begin
                if (op_ok_reg)
                begin
                    for (int u = 0; u < csc_pkg::TRANSACTIONS; u++)
                    begin
                        if (sources[u])
                        begin
                            rows_next[u] = rows_reg[u] | self_mask;
                        end
                    end
                end
                state_next = ST_IDLE;
            end
            ST_CLOSE:
            begin
                // Warshall step on pivot k, every row at once
                for (int i = 0; i < csc_pkg::TRANSACTIONS; i++)
                begin
                    if (rows_reg[i][k_reg])
                    begin
                        rows_next[i] = rows_reg[i] | rows_reg[k_reg];
                    end
                end
                k_next = k_reg + 1'b1;
                if (k_reg == csc_pkg::TXN_AW'(csc_pkg::TRANSACTIONS - 1))
                begin
                    state_next = ST_REPORT;
                end
            end
            ST_REPORT:
            begin
                done_next = 1'b1;
                ser_next  = !cyclic;
                for (int i = 0; i < csc_pkg::TRANSACTIONS; i++)
                begin
                    rows_next[i] = '0;
                end
                clr_next   = '0;
                state_next = ST_CLEAR;
            end
            ST_CLEAR:
            begin
                clr_next = clr_reg + 1'b1;
                if (clr_reg == csc_pkg::ITEM_AW'(csc_pkg::ITEMS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            k_reg     <= '0;
            clr_reg   <= '0;
            done_reg  <= 1'b0;
            ser_reg   <= 1'b0;
            for (int i = 0; i < csc_pkg::TRANSACTIONS; i++)
            begin
                rows_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            k_reg     <= k_next;
            clr_reg   <= clr_next;
            done_reg  <= done_next;
            ser_reg   <= ser_next;
            for (int i = 0; i < csc_pkg::TRANSACTIONS; i++)
            begin
                rows_reg[i] <= rows_next[i];
            end
        end
    end

    a_done_then_clear: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> state_reg == ST_CLEAR)
        else $error("result beat not followed by the clearing sweep");

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe longer than one cycle");

    a_op_to_upd: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !action) |=> state_reg == ST_UPD)
        else $error("operation beat did not go to the update cycle");

    a_eval_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && action) |=> (busy && k_reg == '0))
        else $error("evaluate beat did not start closure at pivot zero");

endmodule

`default_nettype wire
